// File: rtl/core/nlt_pkg.sv
package nlt_pkg;

   // Table geometry
   localparam int NEIGHBORS  = 16;
   localparam int NBR_IDX_W  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
   localparam int NBR_CNT_W  = $clog2(NEIGHBORS + 1);
   localparam int APP_SUM_W  = 8 + NBR_CNT_W;

   // Field widths
   localparam int OP_W       = 2;
   localparam int TIME_W     = 32;
   localparam int SLOT_W     = 4;
   localparam int APPS_W     = 8;
   localparam int INTERVAL_W = 16;
   localparam int SITES_W    = 5;
   localparam int TOTAL_W    = 13;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_INTERVAL = 1'b0;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd500;
   localparam logic [APPS_W-1:0]     PONG_MAX       = 8'd255;

   // Operation codes
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_PONG   = 2'd1;
   localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] now_ms;
      logic [SLOT_W-1:0] site_index;
      logic [APPS_W-1:0] neighbor_apps;
   } req_type;

   typedef struct packed {
      logic               ping_neighbors;
      logic               network_changed;
      logic [SITES_W-1:0] site_count;
      logic [TOTAL_W-1:0] total_apps;
      logic [APPS_W-1:0]  local_apps;
   } rsp_type;

   // One table entry
   typedef struct packed {
      logic [APPS_W-1:0] apps;
      logic [TIME_W-1:0] last_seen;
   } entry_type;

   // Control word from the sequencer to the table
   typedef struct packed {
      logic                 wr_en;
      logic [NBR_IDX_W-1:0] wr_idx;
      entry_type            wr_entry;
      logic [NBR_IDX_W-1:0] rd_idx;
      logic                 drop_en;
      logic [NEIGHBORS-1:0] drop_mask;
   } tbl_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/core/nlt_table.sv
module nlt_table (
   input  logic                   clock,
   input  logic                   reset,
   input  nlt_pkg::tbl_ctrl_type  ctrl,
   output nlt_pkg::entry_type     rd_entry,
   output logic                   rd_valid
);

   nlt_pkg::entry_type            mem [nlt_pkg::NEIGHBORS];
   nlt_pkg::entry_type            rd_entry_ff;
   logic                          rd_valid_ff;
   logic [nlt_pkg::NEIGHBORS-1:0] valid_ff;
   logic [nlt_pkg::NEIGHBORS-1:0] valid_in;

   // Entry storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_idx] <= ctrl.wr_entry;
      end
      rd_entry_ff <= mem[ctrl.rd_idx];
   end

   // Valid marks: set on report, cleared by the drop mask
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.drop_en) begin
         valid_in = valid_in & ~ctrl.drop_mask;
      end
      if (ctrl.wr_en) begin
         valid_in[ctrl.wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[ctrl.rd_idx];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// File: rtl/core/neighbor_liveness_table_top.sv
// Channel  | Direction | Ports                                  | Handshake
// request  | in        | start, busy, req_data                  | start && !busy
// response | out       | rsp_valid, rsp_data                    | one-cycle strobe
// config   | in/out    | csr_psel/penable/pwrite/paddr/pwdata   | APB access phase
//
// Pong and report words are handled while idle; busy stays low.
// During a tick the scan reads one table entry per cycle from the single read
// port, then the finish state closes the totals. The result strobe follows in
// the next cycle, while the next word may be accepted.
// Synchronous active-high reset clears valid marks, counters and totals.
// The receiver cannot stall; results are never held.
module neighbor_liveness_table_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  nlt_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output nlt_pkg::rsp_type                    rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nlt_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [nlt_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [nlt_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int SCAN_W = nlt_pkg::NBR_CNT_W;

   nlt_pkg::state_type                  state_ff, state_in;
   logic [SCAN_W-1:0]                   scan_ff, scan_in;
   logic [nlt_pkg::INTERVAL_W-1:0]      interval_ff;
   logic [nlt_pkg::TIME_W-1:0]          now_ff;
   logic [nlt_pkg::APPS_W-1:0]          pong_ff, pong_in;
   logic [nlt_pkg::APPS_W-1:0]          local_ff, local_in;
   logic [nlt_pkg::TOTAL_W-1:0]         last_total_ff, last_total_in;
   logic [nlt_pkg::SITES_W-1:0]         last_sites_ff, last_sites_in;
   logic                                stale_ff, stale_in;
   logic [nlt_pkg::NEIGHBORS-1:0]       old_ff, old_in;
   logic [nlt_pkg::NBR_CNT_W-1:0]       cnt_all_ff, cnt_all_in;
   logic [nlt_pkg::NBR_CNT_W-1:0]       cnt_keep_ff, cnt_keep_in;
   logic [nlt_pkg::APP_SUM_W-1:0]       sum_all_ff, sum_all_in;
   logic [nlt_pkg::APP_SUM_W-1:0]       sum_keep_ff, sum_keep_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   nlt_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   nlt_pkg::tbl_ctrl_type               tbl_ctrl;
   nlt_pkg::entry_type                  rd_entry;
   logic                                rd_valid;

   logic                                accept;
   logic                                csr_wr;
   logic [nlt_pkg::TIME_W-1:0]          age;
   logic                                is_stale;
   logic                                is_old;
   logic [nlt_pkg::NBR_CNT_W-1:0]       cnt_sel;
   logic [nlt_pkg::APP_SUM_W-1:0]       sum_sel;
   logic [nlt_pkg::SITES_W-1:0]         sites;
   logic [nlt_pkg::TOTAL_W-1:0]         total;

   assign accept = start && !busy;
   assign busy   = (state_ff != nlt_pkg::ST_IDLE);

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= nlt_pkg::INTERVAL_RESET;
      end else if (csr_wr && (csr_paddr[2] == nlt_pkg::CSR_IDX_INTERVAL)) begin
         interval_ff <= csr_pwdata[nlt_pkg::INTERVAL_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == nlt_pkg::CSR_IDX_INTERVAL) begin
         csr_prdata = nlt_pkg::CSR_DATA_W'(interval_ff);
      end
   end

   nlt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (tbl_ctrl),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid)
   );

   // Age of the entry coming out of the read port
   assign age      = now_ff - rd_entry.last_seen;
   assign is_stale = rd_valid && (age >= nlt_pkg::TIME_W'(interval_ff));
   assign is_old   = rd_valid && (age > nlt_pkg::TIME_W'({interval_ff, 1'b0}));

   // Totals after optional removal
   assign cnt_sel = stale_ff ? cnt_keep_ff : cnt_all_ff;
   assign sum_sel = stale_ff ? sum_keep_ff : sum_all_ff;
   assign sites   = nlt_pkg::SITES_W'(cnt_sel + 1'b1);
   assign total   = nlt_pkg::TOTAL_W'(sum_sel + nlt_pkg::APP_SUM_W'(pong_ff));

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      pong_in       = pong_ff;
      local_in      = local_ff;
      last_total_in = last_total_ff;
      last_sites_in = last_sites_ff;
      stale_in      = stale_ff;
      old_in        = old_ff;
      cnt_all_in    = cnt_all_ff;
      cnt_keep_in   = cnt_keep_ff;
      sum_all_in    = sum_all_ff;
      sum_keep_in   = sum_keep_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;

      tbl_ctrl                    = '0;
      tbl_ctrl.wr_idx             = nlt_pkg::NBR_IDX_W'(req_data.site_index);
      tbl_ctrl.wr_entry.apps      = req_data.neighbor_apps;
      tbl_ctrl.wr_entry.last_seen = req_data.now_ms;
      tbl_ctrl.rd_idx             = scan_ff[nlt_pkg::NBR_IDX_W-1:0];
      tbl_ctrl.drop_mask          = old_ff;

      unique case (state_ff)
         nlt_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (req_data.op == nlt_pkg::OP_PONG) begin
                  if (pong_ff < nlt_pkg::PONG_MAX) begin
                     pong_in = pong_ff + 1'b1;
                  end
               end else if (req_data.op == nlt_pkg::OP_REPORT) begin
                  tbl_ctrl.wr_en = (int'(req_data.site_index) < nlt_pkg::NEIGHBORS);
               end else if (req_data.op == nlt_pkg::OP_TICK) begin
                  state_in    = nlt_pkg::ST_SCAN;
                  scan_in     = '0;
                  stale_in    = 1'b0;
                  old_in      = '0;
                  cnt_all_in  = '0;
                  cnt_keep_in = '0;
                  sum_all_in  = '0;
                  sum_keep_in = '0;
               end else begin
                  state_in = nlt_pkg::ST_IDLE;
               end
            end
         end

         nlt_pkg::ST_SCAN: begin
            // Read issued at scan_ff, data of the previous slot arrives now
            scan_in = scan_ff + 1'b1;
            if (scan_ff != '0) begin
               stale_in = stale_ff || is_stale;
               old_in   = {is_old, old_ff[nlt_pkg::NEIGHBORS-1:1]};
               if (rd_valid) begin
                  cnt_all_in = cnt_all_ff + 1'b1;
                  sum_all_in = sum_all_ff + nlt_pkg::APP_SUM_W'(rd_entry.apps);
               end
               if (rd_valid && !is_old) begin
                  cnt_keep_in = cnt_keep_ff + 1'b1;
                  sum_keep_in = sum_keep_ff + nlt_pkg::APP_SUM_W'(rd_entry.apps);
               end
            end
            if (scan_ff == SCAN_W'(nlt_pkg::NEIGHBORS)) begin
               state_in = nlt_pkg::ST_FINISH;
            end
         end

         nlt_pkg::ST_FINISH: begin
            tbl_ctrl.drop_en            = stale_ff;
            local_in                    = pong_ff;
            pong_in                     = '0;
            last_sites_in               = sites;
            last_total_in               = total;
            rsp_valid_in                = 1'b1;
            rsp_data_in.ping_neighbors  = stale_ff;
            rsp_data_in.network_changed = (sites != last_sites_ff) ||
                                          (total != last_total_ff);
            rsp_data_in.site_count      = sites;
            rsp_data_in.total_apps      = total;
            rsp_data_in.local_apps      = pong_ff;
            state_in                    = nlt_pkg::ST_IDLE;
         end

         default: begin
            state_in = nlt_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nlt_pkg::ST_IDLE;
         pong_ff       <= '0;
         local_ff      <= '0;
         last_total_ff <= '0;
         last_sites_ff <= nlt_pkg::SITES_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pong_ff       <= pong_in;
         local_ff      <= local_in;
         last_total_ff <= last_total_in;
         last_sites_ff <= last_sites_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Scan working registers
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      stale_ff    <= stale_in;
      old_ff      <= old_in;
      cnt_all_ff  <= cnt_all_in;
      cnt_keep_ff <= cnt_keep_in;
      sum_all_ff  <= sum_all_in;
      sum_keep_ff <= sum_keep_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         now_ff <= req_data.now_ms;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: dv/neighbor_liveness_table_top_tb.sv
`timescale 1ns / 100ps

module neighbor_liveness_table_top_tb;
   import nlt_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] INTERVAL_ADDR = CSR_ADDR_W'(CSR_IDX_INTERVAL) << 2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // a tick scans the whole table, plus margin for the result strobe
   localparam int SETTLE_CYCLES = NEIGHBORS + 8;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Shadow of the neighbor table and counters
   bit                     live_mark [NEIGHBORS];
   logic [APPS_W-1:0]      live_apps [NEIGHBORS];
   logic [TIME_W-1:0]      heard_at [NEIGHBORS];
   logic [APPS_W-1:0]      pong_cnt;
   logic [APPS_W-1:0]      local_cnt;
   logic [TOTAL_W-1:0]     prev_total;
   logic [SITES_W-1:0]     prev_sites;
   logic [INTERVAL_W-1:0]  interval_ms;

   rsp_type reports_due[$];
   rsp_type due_report;
   int unsigned mismatch_count = 0;
   bit no_idle = 1'b0;

   neighbor_liveness_table_top uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic void flag_mismatch(input string what, input logic [31:0] want_v,
                                         input logic [31:0] got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("MISMATCH %0s: expected %h, got %h", what, want_v, got_v);
   endfunction

   // Update the shadow table for one accepted word; a tick queues its report
   function automatic void advance_table(input req_type w);
      logic [TIME_W-1:0]     age;
      logic [INTERVAL_W:0]   drop_age;
      bit                    stale;
      int unsigned           sites;
      int unsigned           total;
      rsp_type               r;
      case (w.op)
         OP_PONG: begin
            if (pong_cnt != PONG_MAX)
               pong_cnt++;
         end
         OP_REPORT: begin
            if (w.site_index < NEIGHBORS) begin
               live_mark[w.site_index] = 1'b1;
               live_apps[w.site_index] = w.neighbor_apps;
               heard_at[w.site_index]  = w.now_ms;
            end
         end
         OP_TICK: begin
            stale = 1'b0;
            for (int i = 0; i < NEIGHBORS; i++) begin
               age = w.now_ms - heard_at[i];
               if (live_mark[i] && age >= interval_ms)
                  stale = 1'b1;
            end
            // removal only happens on a tick that saw stale info
            if (stale) begin
               drop_age = {interval_ms, 1'b0};
               for (int i = 0; i < NEIGHBORS; i++) begin
                  age = w.now_ms - heard_at[i];
                  if (live_mark[i] && age > drop_age)
                     live_mark[i] = 1'b0;
               end
            end
            local_cnt = pong_cnt;
            pong_cnt  = '0;
            sites = 1;
            total = 32'(local_cnt);
            for (int i = 0; i < NEIGHBORS; i++) begin
               if (live_mark[i]) begin
                  sites++;
                  total += 32'(live_apps[i]);
               end
            end
            r.ping_neighbors  = stale;
            r.site_count      = sites[SITES_W-1:0];
            r.total_apps      = total[TOTAL_W-1:0];
            r.local_apps      = local_cnt;
            r.network_changed = (r.site_count != prev_sites) || (r.total_apps != prev_total);
            prev_sites = r.site_count;
            prev_total = r.total_apps;
            reports_due.push_back(r);
         end
         default: ;
      endcase
   endfunction

   // Result checker: every strobe must match the oldest due report
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (reports_due.size() == 0) begin
            flag_mismatch("result with none due", '0, 32'(rsp_data));
         end else begin
            due_report = reports_due.pop_front();
            if (rsp_data.ping_neighbors !== due_report.ping_neighbors)
               flag_mismatch("ping_neighbors", 32'(due_report.ping_neighbors),
                             32'(rsp_data.ping_neighbors));
            if (rsp_data.network_changed !== due_report.network_changed)
               flag_mismatch("network_changed", 32'(due_report.network_changed),
                             32'(rsp_data.network_changed));
            if (rsp_data.site_count !== due_report.site_count)
               flag_mismatch("site_count", 32'(due_report.site_count),
                             32'(rsp_data.site_count));
            if (rsp_data.total_apps !== due_report.total_apps)
               flag_mismatch("total_apps", 32'(due_report.total_apps),
                             32'(rsp_data.total_apps));
            if (rsp_data.local_apps !== due_report.local_apps)
               flag_mismatch("local_apps", 32'(due_report.local_apps),
                             32'(rsp_data.local_apps));
         end
      end
   end

   // Send one word and hold it until accepted, then idle for a random, possibly empty, gap
   task automatic send_word(input req_type w);
      int unsigned gap;
      int unsigned roll;
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      advance_table(w);
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 45)
         gap = 0;
      else if (roll < 85)
         gap = $urandom_range(1, 3);
      else if (roll < 97)
         gap = $urandom_range(4, 20);
      else
         gap = $urandom_range(21, 80);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain outstanding reports and let a trailing tick finish
   task automatic quiesce();
      int unsigned guard;
      start <= 1'b0;
      for (guard = 0; reports_due.size() != 0 && guard < 5000; guard++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic req_type word_of(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                                       input logic [SLOT_W-1:0] idx,
                                       input logic [APPS_W-1:0] apps);
      req_type w;
      w.op            = op;
      w.now_ms        = t;
      w.site_index    = idx;
      w.neighbor_apps = apps;
      return w;
   endfunction

   // Hand-picked words at the reset interval of 500 ms
   task automatic test_directed_cases();
      // empty table
      send_word(word_of(OP_TICK, 32'h0, 4'd0, 8'd0));
      send_word(word_of(OP_PONG, 32'hFFFF_FFFF, 4'd15, 8'hFF));
      send_word(word_of(OP_PONG, 32'h0, 4'd0, 8'd0));
      // extremes of slot, count and time; slot 7 overwritten
      send_word(word_of(OP_REPORT, 32'hFFFF_FF00, 4'd0, 8'd255));
      send_word(word_of(OP_REPORT, 32'h0, 4'd15, 8'd0));
      send_word(word_of(OP_REPORT, 32'd100, 4'd7, 8'd10));
      send_word(word_of(OP_REPORT, 32'd200, 4'd7, 8'd200));
      send_word(word_of(OP_UNUSED, 32'hFFFF_FFFF, 4'd15, 8'd255));
      // slot 0 stale across the wrap, nothing old enough to drop
      send_word(word_of(OP_TICK, 32'd300, 4'd0, 8'd0));
      // all three dropped
      send_word(word_of(OP_TICK, 32'd1500, 4'd0, 8'd0));
      // one entry walked across both boundaries
      send_word(word_of(OP_REPORT, 32'd1500, 4'd3, 8'd1));
      send_word(word_of(OP_TICK, 32'd1999, 4'd0, 8'd0));
      send_word(word_of(OP_TICK, 32'd2000, 4'd0, 8'd0));
      send_word(word_of(OP_TICK, 32'd2500, 4'd0, 8'd0));
      send_word(word_of(OP_TICK, 32'd2501, 4'd0, 8'd0));
      send_word(word_of(OP_TICK, 32'd2501, 4'd0, 8'd0));
      // age exactly one interval across the wrap
      send_word(word_of(OP_REPORT, 32'hFFFF_FFFF, 4'd8, 8'd128));
      send_word(word_of(OP_TICK, 32'h0000_01F3, 4'd0, 8'd0));
      send_word(word_of(OP_UNUSED, 32'h0, 4'd0, 8'd0));
      send_word(word_of(OP_TICK, 32'h0000_01F4, 4'd0, 8'd0));
      quiesce();
   endtask

   // Pong counter must stop at its maximum and clear on a tick
   task automatic test_pong_saturation();
      no_idle = 1'b1;
      repeat (300) send_word(word_of(OP_PONG, $urandom, 4'($urandom), 8'($urandom)));
      send_word(word_of(OP_TICK, $urandom, 4'd0, 8'd0));
      send_word(word_of(OP_PONG, $urandom, 4'd0, 8'd0));
      send_word(word_of(OP_TICK, $urandom, 4'd0, 8'd0));
      no_idle = 1'b0;
      quiesce();
   endtask

   // Program the interval, then random traffic with a running clock that
   // mostly advances by up to one interval per word
   task automatic run_aging_phase(input logic [INTERVAL_W-1:0] ivl, input int unsigned count);
      logic [TIME_W-1:0] cur_ms;
      logic [TIME_W-1:0] span;
      logic [CSR_DATA_W-1:0] wdata;
      req_type w;
      int unsigned pick;
      int unsigned slot;
      // register write: setup then access, upper bits are don't-care
      wdata = {16'($urandom), ivl};
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= INTERVAL_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      interval_ms = wdata[INTERVAL_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // read it back
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== CSR_DATA_W'(interval_ms))
         flag_mismatch("interval readback", CSR_DATA_W'(interval_ms), csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;

      span = (ivl == 0) ? 32'd2 : 32'(ivl);
      if ($urandom_range(0, 1) == 1)
         cur_ms = $urandom;
      else
         cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * span);
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         w.op = (pick < 25) ? OP_TICK : (pick < 55) ? OP_PONG :
                (pick < 95) ? OP_REPORT : OP_UNUSED;
         w.site_index = SLOT_W'($urandom_range(0, NEIGHBORS - 1));
         pick = $urandom_range(0, 9);
         w.neighbor_apps = (pick == 0) ? '0 : (pick == 1) ? '1 : APPS_W'($urandom);
         pick = $urandom_range(0, 9);
         slot = $urandom_range(0, NEIGHBORS - 1);
         if (pick == 0) begin
            // stray time, unrelated to the running clock
            w.now_ms = $urandom;
         end else if (pick < 4 && live_mark[slot]) begin
            // land right on an aging boundary of a live entry
            case ($urandom_range(0, 3))
               0: cur_ms = heard_at[slot] + ivl - 1;
               1: cur_ms = heard_at[slot] + ivl;
               2: cur_ms = heard_at[slot] + 2 * ivl;
               default: cur_ms = heard_at[slot] + 2 * ivl + 1;
            endcase
            w.now_ms = cur_ms;
         end else begin
            cur_ms += $urandom_range(0, span);
            w.now_ms = cur_ms;
         end
         send_word(w);
      end
      no_idle = 1'b0;
      quiesce();
   endtask

   task automatic test_extreme_intervals();
      run_aging_phase(16'd1, 130);
      run_aging_phase(16'hFFFF, 130);
      run_aging_phase(16'd0, 130);
   endtask

   task automatic test_assorted_intervals();
      run_aging_phase(INTERVAL_RESET, 130);
      run_aging_phase(16'd2, 130);
      run_aging_phase(16'd7, 130);
      run_aging_phase(16'd100, 130);
      repeat (2) run_aging_phase(16'($urandom_range(1, 65535)), 130);
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      for (int i = 0; i < NEIGHBORS; i++) begin
         live_mark[i] = 1'b0;
         live_apps[i] = '0;
         heard_at[i]  = '0;
      end
      pong_cnt    = '0;
      local_cnt   = '0;
      prev_total  = '0;
      prev_sites  = SITES_W'(1);
      interval_ms = INTERVAL_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_pong_saturation();
      test_extreme_intervals();
      test_assorted_intervals();

      if (reports_due.size() != 0)
         flag_mismatch("reports never returned", '0, reports_due.size());
      if (mismatch_count == 0)
         $display("neighbor_liveness_table_top verification clean");
      else
         $display("neighbor_liveness_table_top verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #3000000;
      $display("neighbor_liveness_table_top verification failed");
      $finish;
   end

endmodule
